### src/tsp_pkg.sv
// Shared types and constants for the traffic signal phase controller.
// Holds the input and result item structs, walk light codes and register map.
// No dependencies.
`default_nettype none

package tsp_pkg;

  localparam int unsigned TickW = 32;
  localparam int unsigned CfgIdxW = 2;

  typedef logic [1:0] walk_t;
  localparam walk_t WALK_RED     = 2'd0;
  localparam walk_t WALK_REQUEST = 2'd1;
  localparam walk_t WALK_GREEN   = 2'd2;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_YELLOW    = 2'd0;
  localparam cfg_idx_t REG_NO_CAR    = 2'd1;
  localparam cfg_idx_t REG_RED_MAX   = 2'd2;
  localparam cfg_idx_t REG_PED_WAIT  = 2'd3;

  localparam logic [TickW-1:0] YELLOW_TICKS_RST   = 32'd2000;
  localparam logic [TickW-1:0] NO_CAR_HOLD_RST    = 32'd5000;
  localparam logic [TickW-1:0] RED_MAX_RST        = 32'd10000;
  localparam logic [TickW-1:0] PED_WAIT_RST       = 32'd2000;

  typedef struct packed {
    logic [TickW-1:0] now_ticks;
    logic             car_lane_one;
    logic             car_lane_two;
    logic             car_lane_three;
    logic             car_lane_four;
    walk_t            walk_vertical;
    walk_t            walk_horizontal;
  } tsp_in_t;

  typedef struct packed {
    logic [1:0] car_phase;
    logic       phase_changed;
  } tsp_out_t;

endpackage

`default_nettype wire

### src/traffic_signal_phase_controller.sv
// Traffic signal phase controller: car phase sequencing with pedestrian hold.
// An accepted item is held in the input register, then its result in the output register.
// Throughput: one item per cycle while out_stall is low; an empty input register
// takes a new item while a result waits in the output register.
// Reset: phase vertical green, all stamps invalid, registers at defaults.
// Depends on tsp_pkg.
`default_nettype none

module traffic_signal_phase_controller (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire tsp_pkg::tsp_in_t          in_data,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output tsp_pkg::tsp_out_t              out_data,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire tsp_pkg::cfg_idx_t         cfg_index,
  input  wire logic [tsp_pkg::TickW-1:0] cfg_data
);
  import tsp_pkg::*;

  typedef enum logic [1:0] {
    PH_GREEN  = 2'd0,
    PH_YELLOW = 2'd1,
    PH_RED    = 2'd2
  } phase_t;

  logic [TickW-1:0] yellow_r, no_car_r, red_max_r, ped_wait_r;

  logic     in_valid_r, in_valid_nxt;
  tsp_in_t  in_data_r;
  logic     out_valid_r, out_valid_nxt;
  tsp_out_t out_data_r, out_data_nxt;
  logic     adv;

  phase_t           phase_r, phase_nxt;
  phase_t           before_r, before_nxt;
  logic [TickW-1:0] start_r, start_nxt;
  logic             req_v_r, req_v_nxt;
  logic [TickW-1:0] req_at_r, req_at_nxt;
  logic             empty_v_r, empty_v_nxt;
  logic [TickW-1:0] empty_at_r, empty_at_nxt;
  logic             cw_v_r, cw_v_nxt;
  logic [TickW-1:0] cw_at_r, cw_at_nxt;

  logic [TickW-1:0] now;
  logic             vert, horiz, active, idle;
  walk_t            own_walk, cross_walk;
  logic             req_wait, empty_wait, cw_wait, go, changed;

  assign adv       = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && out_valid_r && out_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign in_valid_nxt  = (in_valid && !in_stall) || (in_valid_r && !adv);
  assign out_valid_nxt = adv || (out_valid_r && out_stall);

  assign now   = in_data_r.now_ticks;
  assign vert  = in_data_r.car_lane_two || in_data_r.car_lane_four;
  assign horiz = in_data_r.car_lane_one || in_data_r.car_lane_three;

  always_comb begin
    active     = (phase_r == PH_GREEN) ? vert : horiz;
    idle       = (phase_r == PH_GREEN) ? horiz : vert;
    own_walk   = (phase_r == PH_GREEN) ? in_data_r.walk_vertical : in_data_r.walk_horizontal;
    cross_walk = (phase_r == PH_GREEN) ? in_data_r.walk_horizontal : in_data_r.walk_vertical;
    req_wait   = req_v_r   ? ((now - req_at_r) < ped_wait_r)  : (ped_wait_r != '0);
    empty_wait = empty_v_r ? ((now - empty_at_r) < no_car_r)  : (no_car_r != '0);
    cw_wait    = cw_v_r    ? ((now - cw_at_r) < red_max_r)    : (red_max_r != '0);

    phase_nxt    = phase_r;
    before_nxt   = before_r;
    start_nxt    = start_r;
    req_v_nxt    = req_v_r;
    req_at_nxt   = req_at_r;
    empty_v_nxt  = empty_v_r;
    empty_at_nxt = empty_at_r;
    cw_v_nxt     = cw_v_r;
    cw_at_nxt    = cw_at_r;
    go           = 1'b0;
    changed      = 1'b0;

    case (phase_r)
      PH_GREEN, PH_RED: begin
        if (cross_walk == WALK_GREEN || cross_walk == WALK_REQUEST) begin
          go = 1'b0;
        end else if (own_walk == WALK_REQUEST) begin
          if (!req_v_r) begin
            req_v_nxt  = 1'b1;
            req_at_nxt = now;
          end
          if (!req_wait) begin
            go        = 1'b1;
            req_v_nxt = 1'b0;
          end
        end else if (!active && !idle) begin
          cw_v_nxt = 1'b0;
          if (!empty_v_r) begin
            empty_v_nxt  = 1'b1;
            empty_at_nxt = now;
          end
          go = !empty_wait;
        end else if (active && !idle) begin
          cw_v_nxt    = 1'b0;
          empty_v_nxt = 1'b0;
        end else if (active && idle) begin
          empty_v_nxt = 1'b0;
          if (!cw_v_r) begin
            cw_v_nxt  = 1'b1;
            cw_at_nxt = now;
          end
          go = !cw_wait;
        end else begin
          go = 1'b1;
        end
        if (go) begin
          before_nxt  = phase_r;
          phase_nxt   = PH_YELLOW;
          cw_v_nxt    = 1'b0;
          empty_v_nxt = 1'b0;
          start_nxt   = now;
          changed     = 1'b1;
        end
      end
      PH_YELLOW: begin
        if ((now - start_r) >= yellow_r) begin
          phase_nxt  = (before_r == PH_GREEN) ? PH_RED : PH_GREEN;
          before_nxt = PH_YELLOW;
          start_nxt  = now;
          changed    = 1'b1;
        end
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase

    out_data_nxt.car_phase     = phase_nxt;
    out_data_nxt.phase_changed = changed;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yellow_r    <= YELLOW_TICKS_RST;
      no_car_r    <= NO_CAR_HOLD_RST;
      red_max_r   <= RED_MAX_RST;
      ped_wait_r  <= PED_WAIT_RST;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_GREEN;
      before_r    <= PH_GREEN;
      start_r     <= '0;
      req_v_r     <= 1'b0;
      empty_v_r   <= 1'b0;
      cw_v_r      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_YELLOW:   yellow_r   <= cfg_data;
          REG_NO_CAR:   no_car_r   <= cfg_data;
          REG_RED_MAX:  red_max_r  <= cfg_data;
          REG_PED_WAIT: ped_wait_r <= cfg_data;
          default:      yellow_r   <= yellow_r;
        endcase
      end
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        phase_r    <= phase_nxt;
        before_r   <= before_nxt;
        start_r    <= start_nxt;
        req_v_r    <= req_v_nxt;
        empty_v_r  <= empty_v_nxt;
        cw_v_r     <= cw_v_nxt;
        req_at_r   <= req_at_nxt;
        empty_at_r <= empty_at_nxt;
        cw_at_r    <= cw_at_nxt;
        out_data_r <= out_data_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
  end

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid_r |-> !in_stall)
    else $error("input stalled with empty input register");

  a_phase_holds_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(phase_r))
    else $error("phase moved without an item");

  a_change_moves_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && changed) |=> (phase_r != $past(phase_r)))
    else $error("reported change without a phase move");

  a_result_matches_phase: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> (out_data_r.car_phase == phase_r))
    else $error("result phase differs from held phase");

endmodule

`default_nettype wire
